>>> hdl/lls_pkg.sv
package lls_pkg;

	localparam int unsigned CFG_W  = 18;
	localparam int unsigned MS_W   = 10;
	localparam int unsigned HDR_W  = 56;
	localparam int unsigned CIDX_W = 2;

	localparam logic [CFG_W-1:0] RETRY_PERIOD_RST   = 18'd10000;
	localparam logic [CFG_W-1:0] TIMEOUT_PERIOD_RST = 18'd60000;

	localparam logic [CIDX_W-1:0] CFG_RETRY_PERIOD   = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_TIMEOUT_PERIOD = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_OPTIONS        = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_DATA_EN        = 2'd3;

	localparam logic [31:0] TAG_DMRD    = 32'h444D5244;
	localparam logic [47:0] TAG_MSTNAK  = 48'h4D53544E414B;
	localparam logic [47:0] TAG_RPTACK  = 48'h52505441434B;
	localparam logic [39:0] TAG_MSTCL   = 40'h4D5354434C;
	localparam logic [55:0] TAG_MSTPONG = 56'h4D5354504F4E47;
	localparam logic [55:0] TAG_RPTSBKN = 56'h52505453424B4E;

	typedef enum logic [2:0] {
		PH_CONNECT = 3'd0,
		PH_LOGIN   = 3'd1,
		PH_AUTH    = 3'd2,
		PH_CONFIG  = 3'd3,
		PH_OPTIONS = 3'd4,
		PH_RUNNING = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		SEND_NONE    = 3'd0,
		SEND_LOGIN   = 3'd1,
		SEND_AUTH    = 3'd2,
		SEND_CONFIG  = 3'd3,
		SEND_OPTIONS = 3'd4,
		SEND_PING    = 3'd5
	} send_t;

	typedef enum logic [2:0] {
		KIND_DATA    = 3'd0,
		KIND_NAK     = 3'd1,
		KIND_ACK     = 3'd2,
		KIND_CLOSE   = 3'd3,
		KIND_PONG    = 3'd4,
		KIND_BEACON  = 3'd5,
		KIND_UNKNOWN = 3'd6
	} pkt_kind_t;

	typedef struct packed {
		logic [MS_W-1:0]  elapsed_ms;
		logic             packet_valid;
		logic             from_master;
		logic [HDR_W-1:0] header_bytes;
		logic             socket_failed;
		logic             open_ok;
	} item_t;

	typedef struct packed {
		logic [CFG_W-1:0] retry_period_ms;
		logic [CFG_W-1:0] timeout_period_ms;
		logic             options_present;
		logic             data_enabled;
	} cfg_t;

	typedef struct packed {
		phase_t link_state;
		send_t  reply_send;
		send_t  timer_send;
		logic   accept_data;
		logic   beacon_request;
		logic   reconnect;
		logic   unknown_packet;
	} result_t;

	function automatic send_t retry_packet(input phase_t ph);
		send_t s;
		case (ph)
			PH_LOGIN:   s = SEND_LOGIN;
			PH_AUTH:    s = SEND_AUTH;
			PH_CONFIG:  s = SEND_CONFIG;
			PH_OPTIONS: s = SEND_OPTIONS;
			PH_RUNNING: s = SEND_PING;
			default:    s = SEND_NONE;
		endcase
		return s;
	endfunction

endpackage

>>> hdl/lls_tag_decode.sv
module lls_tag_decode (
	input  logic [lls_pkg::HDR_W-1:0] header_bytes,
	output lls_pkg::pkt_kind_t        kind
);

	always_comb begin
		if (header_bytes[55:24] == lls_pkg::TAG_DMRD) begin
			kind = lls_pkg::KIND_DATA;
		end else if (header_bytes[55:8] == lls_pkg::TAG_MSTNAK) begin
			kind = lls_pkg::KIND_NAK;
		end else if (header_bytes[55:8] == lls_pkg::TAG_RPTACK) begin
			kind = lls_pkg::KIND_ACK;
		end else if (header_bytes[55:16] == lls_pkg::TAG_MSTCL) begin
			kind = lls_pkg::KIND_CLOSE;
		end else if (header_bytes == lls_pkg::TAG_MSTPONG) begin
			kind = lls_pkg::KIND_PONG;
		end else if (header_bytes == lls_pkg::TAG_RPTSBKN) begin
			kind = lls_pkg::KIND_BEACON;
		end else begin
			kind = lls_pkg::KIND_UNKNOWN;
		end
	end

endmodule

>>> hdl/lls_timer_step.sv
module lls_timer_step #(
	parameter int unsigned TIMER_BITS = 18
) (
	input  logic                       running,
	input  logic [TIMER_BITS-1:0]      count,
	input  logic [lls_pkg::CFG_W-1:0]  period,
	input  logic [lls_pkg::MS_W-1:0]   elapsed_ms,
	output logic [TIMER_BITS-1:0]      count_next,
	output logic                       expired
);

	localparam int unsigned CMP_W = (TIMER_BITS > lls_pkg::CFG_W) ? TIMER_BITS : lls_pkg::CFG_W;

	logic [TIMER_BITS:0] sum;

	assign sum = {1'b0, count} + (TIMER_BITS+1)'(elapsed_ms);

	always_comb begin
		if (!running) begin
			count_next = count;
		end else if (sum[TIMER_BITS]) begin
			count_next = '1;
		end else begin
			count_next = sum[TIMER_BITS-1:0];
		end
	end

	assign expired = running && (period != '0) &&
		(CMP_W'(count_next) >= CMP_W'(period));

endmodule

>>> hdl/lls_step.sv
module lls_step #(
	parameter int unsigned TIMER_BITS = 18
) (
	input  lls_pkg::item_t          item,
	input  lls_pkg::cfg_t           cfg,
	input  lls_pkg::phase_t         phase,
	input  logic                    retry_run,
	input  logic [TIMER_BITS-1:0]   retry_cnt,
	input  logic                    timeout_run,
	input  logic [TIMER_BITS-1:0]   timeout_cnt,
	output lls_pkg::phase_t         phase_nxt,
	output logic                    retry_run_nxt,
	output logic [TIMER_BITS-1:0]   retry_cnt_nxt,
	output logic                    timeout_run_nxt,
	output logic [TIMER_BITS-1:0]   timeout_cnt_nxt,
	output lls_pkg::result_t        res
);

	lls_pkg::pkt_kind_t    kind;
	lls_pkg::phase_t       ph_a;
	logic                  rr_a;
	logic                  tr_a;
	logic [TIMER_BITS-1:0] rc_a;
	logic [TIMER_BITS-1:0] tc_a;
	logic                  stop_a;
	logic                  recon_a;
	logic                  acc_a;
	logic                  bcn_a;
	logic                  unk_a;
	lls_pkg::send_t        reply_a;
	logic [TIMER_BITS-1:0] rc_clk;
	logic [TIMER_BITS-1:0] tc_clk;
	logic                  r_exp;
	logic                  t_exp;

	lls_tag_decode u_tag (
		.header_bytes (item.header_bytes),
		.kind         (kind)
	);

	// packet stage
	always_comb begin
		ph_a    = phase;
		rr_a    = retry_run;
		rc_a    = retry_cnt;
		tr_a    = timeout_run;
		tc_a    = timeout_cnt;
		stop_a  = 1'b0;
		recon_a = 1'b0;
		acc_a   = 1'b0;
		bcn_a   = 1'b0;
		unk_a   = 1'b0;
		reply_a = lls_pkg::SEND_NONE;
		if (phase != lls_pkg::PH_CONNECT) begin
			if (item.socket_failed) begin
				stop_a = 1'b1;
			end else if (item.packet_valid && item.from_master) begin
				case (kind)
					lls_pkg::KIND_DATA: begin
						acc_a = cfg.data_enabled;
					end
					lls_pkg::KIND_NAK: begin
						if (phase == lls_pkg::PH_RUNNING) begin
							ph_a = lls_pkg::PH_LOGIN;
							rr_a = 1'b1;
							rc_a = '0;
							tr_a = 1'b1;
							tc_a = '0;
						end else begin
							stop_a = 1'b1;
						end
					end
					lls_pkg::KIND_ACK: begin
						case (phase)
							lls_pkg::PH_LOGIN: begin
								reply_a = lls_pkg::SEND_AUTH;
								ph_a    = lls_pkg::PH_AUTH;
							end
							lls_pkg::PH_AUTH: begin
								reply_a = lls_pkg::SEND_CONFIG;
								ph_a    = lls_pkg::PH_CONFIG;
							end
							lls_pkg::PH_CONFIG: begin
								if (cfg.options_present) begin
									reply_a = lls_pkg::SEND_OPTIONS;
									ph_a    = lls_pkg::PH_OPTIONS;
								end else begin
									ph_a = lls_pkg::PH_RUNNING;
								end
							end
							lls_pkg::PH_OPTIONS: begin
								ph_a = lls_pkg::PH_RUNNING;
							end
							default: begin
							end
						endcase
						if (phase != lls_pkg::PH_RUNNING) begin
							rr_a = 1'b1;
							rc_a = '0;
							tr_a = 1'b1;
							tc_a = '0;
						end
					end
					lls_pkg::KIND_CLOSE: begin
						ph_a    = lls_pkg::PH_CONNECT;
						rr_a    = 1'b1;
						rc_a    = '0;
						tr_a    = 1'b0;
						tc_a    = '0;
						recon_a = 1'b1;
					end
					lls_pkg::KIND_PONG: begin
						tr_a = 1'b1;
						tc_a = '0;
					end
					lls_pkg::KIND_BEACON: begin
						bcn_a = 1'b1;
					end
					default: begin
						unk_a = 1'b1;
					end
				endcase
			end
		end
	end

	lls_timer_step #(.TIMER_BITS(TIMER_BITS)) u_retry (
		.running    (rr_a),
		.count      (rc_a),
		.period     (cfg.retry_period_ms),
		.elapsed_ms (item.elapsed_ms),
		.count_next (rc_clk),
		.expired    (r_exp)
	);

	lls_timer_step #(.TIMER_BITS(TIMER_BITS)) u_timeout (
		.running    (tr_a),
		.count      (tc_a),
		.period     (cfg.timeout_period_ms),
		.elapsed_ms (item.elapsed_ms),
		.count_next (tc_clk),
		.expired    (t_exp)
	);

	// timer stage and result
	always_comb begin
		phase_nxt       = ph_a;
		retry_run_nxt   = rr_a;
		retry_cnt_nxt   = rc_clk;
		timeout_run_nxt = tr_a;
		timeout_cnt_nxt = tc_a;
		res             = '0;
		res.reply_send  = reply_a;
		res.timer_send  = lls_pkg::SEND_NONE;
		res.accept_data = acc_a;
		res.beacon_request = bcn_a;
		res.unknown_packet = unk_a;
		res.reconnect   = recon_a;
		if (phase == lls_pkg::PH_CONNECT) begin
			if (r_exp) begin
				if (item.open_ok) begin
					res.timer_send  = lls_pkg::SEND_LOGIN;
					phase_nxt       = lls_pkg::PH_LOGIN;
					timeout_run_nxt = 1'b1;
					timeout_cnt_nxt = '0;
				end
				retry_run_nxt = 1'b1;
				retry_cnt_nxt = '0;
			end
		end else if (stop_a) begin
			phase_nxt       = lls_pkg::PH_CONNECT;
			retry_run_nxt   = 1'b1;
			retry_cnt_nxt   = '0;
			timeout_run_nxt = 1'b0;
			timeout_cnt_nxt = '0;
			res.reconnect   = 1'b1;
		end else begin
			timeout_cnt_nxt = tc_clk;
			if (r_exp) begin
				res.timer_send = lls_pkg::retry_packet(ph_a);
				retry_run_nxt  = 1'b1;
				retry_cnt_nxt  = '0;
			end
			if (t_exp) begin
				phase_nxt       = lls_pkg::PH_CONNECT;
				retry_run_nxt   = 1'b1;
				retry_cnt_nxt   = '0;
				timeout_run_nxt = 1'b0;
				timeout_cnt_nxt = '0;
				res.reconnect   = 1'b1;
			end
		end
		res.link_state = phase_nxt;
	end

endmodule

>>> hdl/link_login_sequencer_core.sv
// Each transaction passes the input register, then the result register holding state
// update and outputs, before its result is on the outputs.
// Throughput: one transaction per cycle while out_ready holds; the result register frees as it is taken.
// Reset (arst_n low, asynchronous): connect phase, retry timer running at zero,
// timeout timer stopped, periods 10000/60000 ms, options and data disabled.
module link_login_sequencer_core #(
	parameter int unsigned TIMER_BITS = 18
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lls_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [lls_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [lls_pkg::MS_W-1:0]    elapsed_ms,
	input  logic                        packet_valid,
	input  logic                        from_master,
	input  logic [lls_pkg::HDR_W-1:0]   header_bytes,
	input  logic                        socket_failed,
	input  logic                        open_ok,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  link_state,
	output logic [2:0]                  reply_send,
	output logic [2:0]                  timer_send,
	output logic                        accept_data,
	output logic                        beacon_request,
	output logic                        reconnect,
	output logic                        unknown_packet
);

	lls_pkg::cfg_t         cfg_q;
	lls_pkg::phase_t       phase_q;
	logic                  retry_run_q;
	logic [TIMER_BITS-1:0] retry_cnt_q;
	logic                  timeout_run_q;
	logic [TIMER_BITS-1:0] timeout_cnt_q;

	logic                  valid_s1;
	lls_pkg::item_t        item_s1;
	logic                  valid_s2;
	lls_pkg::result_t      res_s2;

	lls_pkg::item_t        item_in;
	logic                  advance;
	lls_pkg::phase_t       phase_nxt;
	logic                  retry_run_nxt;
	logic [TIMER_BITS-1:0] retry_cnt_nxt;
	logic                  timeout_run_nxt;
	logic [TIMER_BITS-1:0] timeout_cnt_nxt;
	lls_pkg::result_t      res_nxt;

	assign item_in.elapsed_ms    = elapsed_ms;
	assign item_in.packet_valid  = packet_valid;
	assign item_in.from_master   = from_master;
	assign item_in.header_bytes  = header_bytes;
	assign item_in.socket_failed = socket_failed;
	assign item_in.open_ok       = open_ok;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.retry_period_ms   <= lls_pkg::RETRY_PERIOD_RST;
			cfg_q.timeout_period_ms <= lls_pkg::TIMEOUT_PERIOD_RST;
			cfg_q.options_present   <= 1'b0;
			cfg_q.data_enabled      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				lls_pkg::CFG_RETRY_PERIOD:   cfg_q.retry_period_ms   <= cfg_data;
				lls_pkg::CFG_TIMEOUT_PERIOD: cfg_q.timeout_period_ms <= cfg_data;
				lls_pkg::CFG_OPTIONS:        cfg_q.options_present   <= cfg_data[0];
				lls_pkg::CFG_DATA_EN:        cfg_q.data_enabled      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_in;
		end
	end

	lls_step #(.TIMER_BITS(TIMER_BITS)) u_step (
		.item            (item_s1),
		.cfg             (cfg_q),
		.phase           (phase_q),
		.retry_run       (retry_run_q),
		.retry_cnt       (retry_cnt_q),
		.timeout_run     (timeout_run_q),
		.timeout_cnt     (timeout_cnt_q),
		.phase_nxt       (phase_nxt),
		.retry_run_nxt   (retry_run_nxt),
		.retry_cnt_nxt   (retry_cnt_nxt),
		.timeout_run_nxt (timeout_run_nxt),
		.timeout_cnt_nxt (timeout_cnt_nxt),
		.res             (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= lls_pkg::PH_CONNECT;
			retry_run_q   <= 1'b1;
			retry_cnt_q   <= '0;
			timeout_run_q <= 1'b0;
			timeout_cnt_q <= '0;
		end else if (advance) begin
			phase_q       <= phase_nxt;
			retry_run_q   <= retry_run_nxt;
			retry_cnt_q   <= retry_cnt_nxt;
			timeout_run_q <= timeout_run_nxt;
			timeout_cnt_q <= timeout_cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid      = valid_s2;
	assign link_state     = res_s2.link_state;
	assign reply_send     = res_s2.reply_send;
	assign timer_send     = res_s2.timer_send;
	assign accept_data    = res_s2.accept_data;
	assign beacon_request = res_s2.beacon_request;
	assign reconnect      = res_s2.reconnect;
	assign unknown_packet = res_s2.unknown_packet;

	a_connect_no_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == lls_pkg::PH_CONNECT |-> !timeout_run_q)
		else $error("timeout timer running in connect phase");

	a_retry_always_on: assert property (@(posedge clk) disable iff (!arst_n)
		retry_run_q)
		else $error("retry timer stopped");

	a_reconnect_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reconnect |-> link_state == lls_pkg::PH_CONNECT)
		else $error("reconnect reported outside connect phase");

	a_data_gated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accept_data |-> cfg_q.data_enabled)
		else $error("data accepted while disabled");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(phase_q) && $stable(retry_cnt_q) && $stable(timeout_cnt_q))
		else $error("link state changed without a transaction");

endmodule

>>> tb/link_login_sequencer_core_tb.sv
module link_login_sequencer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TIMER_BITS = 18;
	localparam logic [TIMER_BITS-1:0] CNT_MAX = '1;

	class login_tracker;
		logic [lls_pkg::CFG_W-1:0] retry_period;
		logic [lls_pkg::CFG_W-1:0] timeout_period;
		logic options_on;
		logic data_on;
		lls_pkg::phase_t ph;
		logic [TIMER_BITS-1:0] retry_cnt;
		logic [TIMER_BITS-1:0] tmo_cnt;
		logic retry_run;
		logic tmo_run;
		lls_pkg::result_t due_reports[$];
		int mismatches;

		function new();
			retry_period = lls_pkg::RETRY_PERIOD_RST;
			timeout_period = lls_pkg::TIMEOUT_PERIOD_RST;
			options_on = 1'b0;
			data_on = 1'b0;
			mismatches = 0;
			reopen();
		endfunction

		function void set_reg(logic [lls_pkg::CIDX_W-1:0] idx, logic [lls_pkg::CFG_W-1:0] val);
			case (idx)
				lls_pkg::CFG_RETRY_PERIOD: retry_period = val;
				lls_pkg::CFG_TIMEOUT_PERIOD: timeout_period = val;
				lls_pkg::CFG_OPTIONS: options_on = val[0];
				lls_pkg::CFG_DATA_EN: data_on = val[0];
				default: ;
			endcase
		endfunction

		function void reopen();
			ph = lls_pkg::PH_CONNECT;
			tmo_run = 1'b0;
			tmo_cnt = '0;
			retry_run = 1'b1;
			retry_cnt = '0;
		endfunction

		function void restart_both();
			tmo_run = 1'b1;
			tmo_cnt = '0;
			retry_run = 1'b1;
			retry_cnt = '0;
		endfunction

		function logic [TIMER_BITS-1:0] sat_add(logic [TIMER_BITS-1:0] a,
				logic [lls_pkg::MS_W-1:0] b);
			logic [TIMER_BITS:0] s;
			s = {1'b0, a} + (TIMER_BITS+1)'(b);
			return s[TIMER_BITS] ? CNT_MAX : s[TIMER_BITS-1:0];
		endfunction

		function bit fired(logic run, logic [TIMER_BITS-1:0] cnt,
				logic [lls_pkg::CFG_W-1:0] period);
			return run && period != 0 && cnt >= period;
		endfunction

		function void take_item(lls_pkg::item_t it);
			lls_pkg::result_t r;
			bit halt;
			r = '0;
			halt = 1'b0;
			if (ph == lls_pkg::PH_CONNECT) begin
				if (retry_run)
					retry_cnt = sat_add(retry_cnt, it.elapsed_ms);
				if (fired(retry_run, retry_cnt, retry_period)) begin
					if (it.open_ok) begin
						r.timer_send = lls_pkg::SEND_LOGIN;
						ph = lls_pkg::PH_LOGIN;
						tmo_run = 1'b1;
						tmo_cnt = '0;
					end
					retry_run = 1'b1;
					retry_cnt = '0;
				end
			end else if (it.socket_failed) begin
				reopen();
				r.reconnect = 1'b1;
			end else begin
				if (it.packet_valid && it.from_master) begin
					if (it.header_bytes[55:24] == lls_pkg::TAG_DMRD) begin
						r.accept_data = data_on;
					end else if (it.header_bytes[55:8] == lls_pkg::TAG_MSTNAK) begin
						if (ph == lls_pkg::PH_RUNNING) begin
							ph = lls_pkg::PH_LOGIN;
							restart_both();
						end else begin
							reopen();
							r.reconnect = 1'b1;
							halt = 1'b1;
						end
					end else if (it.header_bytes[55:8] == lls_pkg::TAG_RPTACK) begin
						case (ph)
							lls_pkg::PH_LOGIN: begin
								r.reply_send = lls_pkg::SEND_AUTH;
								ph = lls_pkg::PH_AUTH;
								restart_both();
							end
							lls_pkg::PH_AUTH: begin
								r.reply_send = lls_pkg::SEND_CONFIG;
								ph = lls_pkg::PH_CONFIG;
								restart_both();
							end
							lls_pkg::PH_CONFIG: begin
								if (options_on) begin
									r.reply_send = lls_pkg::SEND_OPTIONS;
									ph = lls_pkg::PH_OPTIONS;
								end else begin
									ph = lls_pkg::PH_RUNNING;
								end
								restart_both();
							end
							lls_pkg::PH_OPTIONS: begin
								ph = lls_pkg::PH_RUNNING;
								restart_both();
							end
							default: ;
						endcase
					end else if (it.header_bytes[55:16] == lls_pkg::TAG_MSTCL) begin
						reopen();
						r.reconnect = 1'b1;
					end else if (it.header_bytes == lls_pkg::TAG_MSTPONG) begin
						tmo_run = 1'b1;
						tmo_cnt = '0;
					end else if (it.header_bytes == lls_pkg::TAG_RPTSBKN) begin
						r.beacon_request = 1'b1;
					end else begin
						r.unknown_packet = 1'b1;
					end
				end
				if (!halt) begin
					if (retry_run)
						retry_cnt = sat_add(retry_cnt, it.elapsed_ms);
					if (fired(retry_run, retry_cnt, retry_period)) begin
						case (ph)
							lls_pkg::PH_LOGIN: r.timer_send = lls_pkg::SEND_LOGIN;
							lls_pkg::PH_AUTH: r.timer_send = lls_pkg::SEND_AUTH;
							lls_pkg::PH_CONFIG: r.timer_send = lls_pkg::SEND_CONFIG;
							lls_pkg::PH_OPTIONS: r.timer_send = lls_pkg::SEND_OPTIONS;
							lls_pkg::PH_RUNNING: r.timer_send = lls_pkg::SEND_PING;
							default: r.timer_send = lls_pkg::SEND_NONE;
						endcase
						retry_run = 1'b1;
						retry_cnt = '0;
					end
					if (tmo_run)
						tmo_cnt = sat_add(tmo_cnt, it.elapsed_ms);
					if (fired(tmo_run, tmo_cnt, timeout_period)) begin
						reopen();
						r.reconnect = 1'b1;
					end
				end
			end
			r.link_state = ph;
			due_reports.push_back(r);
		endfunction

		function void check_report(lls_pkg::result_t got);
			lls_pkg::result_t e;
			if (due_reports.size() == 0) begin
				$error("result transaction with nothing outstanding");
				mismatches++;
				return;
			end
			e = due_reports.pop_front();
			if (got.link_state !== e.link_state) begin
				$error("link_state expected %0d actual %0d", e.link_state, got.link_state);
				mismatches++;
			end
			if (got.reply_send !== e.reply_send) begin
				$error("reply_send expected %0d actual %0d", e.reply_send, got.reply_send);
				mismatches++;
			end
			if (got.timer_send !== e.timer_send) begin
				$error("timer_send expected %0d actual %0d", e.timer_send, got.timer_send);
				mismatches++;
			end
			if (got.accept_data !== e.accept_data) begin
				$error("accept_data expected %0b actual %0b", e.accept_data, got.accept_data);
				mismatches++;
			end
			if (got.beacon_request !== e.beacon_request) begin
				$error("beacon_request expected %0b actual %0b",
					e.beacon_request, got.beacon_request);
				mismatches++;
			end
			if (got.reconnect !== e.reconnect) begin
				$error("reconnect expected %0b actual %0b", e.reconnect, got.reconnect);
				mismatches++;
			end
			if (got.unknown_packet !== e.unknown_packet) begin
				$error("unknown_packet expected %0b actual %0b",
					e.unknown_packet, got.unknown_packet);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [lls_pkg::CIDX_W-1:0] cfg_index;
	logic [lls_pkg::CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [lls_pkg::MS_W-1:0] elapsed_ms;
	logic packet_valid;
	logic from_master;
	logic [lls_pkg::HDR_W-1:0] header_bytes;
	logic socket_failed;
	logic open_ok;
	logic out_valid;
	logic out_ready;
	logic [2:0] link_state;
	logic [2:0] reply_send;
	logic [2:0] timer_send;
	logic accept_data;
	logic beacon_request;
	logic reconnect;
	logic unknown_packet;

	login_tracker sb;
	int sender_idle = 0;
	int stall_pct = 0;

	link_login_sequencer_core #(
		.TIMER_BITS(TIMER_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.elapsed_ms(elapsed_ms),
		.packet_valid(packet_valid),
		.from_master(from_master),
		.header_bytes(header_bytes),
		.socket_failed(socket_failed),
		.open_ok(open_ok),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.link_state(link_state),
		.reply_send(reply_send),
		.timer_send(timer_send),
		.accept_data(accept_data),
		.beacon_request(beacon_request),
		.reconnect(reconnect),
		.unknown_packet(unknown_packet)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_report({link_state, reply_send, timer_send, accept_data,
					beacon_request, reconnect, unknown_packet});
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic logic [lls_pkg::HDR_W-1:0] header_for(lls_pkg::pkt_kind_t k);
		logic [63:0] raw;
		logic [lls_pkg::HDR_W-1:0] h;
		raw = {$urandom, $urandom};
		h = raw[lls_pkg::HDR_W-1:0];
		case (k)
			lls_pkg::KIND_DATA: h[55:24] = lls_pkg::TAG_DMRD;
			lls_pkg::KIND_NAK: h[55:8] = lls_pkg::TAG_MSTNAK;
			lls_pkg::KIND_ACK: h[55:8] = lls_pkg::TAG_RPTACK;
			lls_pkg::KIND_CLOSE: h[55:16] = lls_pkg::TAG_MSTCL;
			lls_pkg::KIND_PONG: h = lls_pkg::TAG_MSTPONG;
			lls_pkg::KIND_BEACON: h = lls_pkg::TAG_RPTSBKN;
			default: begin
				// near miss on a full-length tag
				if (raw[63])
					h = (raw[62] ? lls_pkg::TAG_RPTSBKN : lls_pkg::TAG_MSTPONG) ^
						(56'd1 << $urandom_range(55));
			end
		endcase
		return h;
	endfunction

	function automatic lls_pkg::item_t mk(int ms, bit pv, bit fm,
			logic [lls_pkg::HDR_W-1:0] hdr, bit sf, bit ok);
		lls_pkg::item_t it;
		it.elapsed_ms = ms[lls_pkg::MS_W-1:0];
		it.packet_valid = pv;
		it.from_master = fm;
		it.header_bytes = hdr;
		it.socket_failed = sf;
		it.open_ok = ok;
		return it;
	endfunction

	function automatic lls_pkg::item_t make_item(lls_pkg::phase_t ph);
		lls_pkg::item_t it;
		int roll;
		lls_pkg::pkt_kind_t k;
		roll = $urandom_range(99);
		if (roll < 15)
			it.elapsed_ms = '0;
		else if (roll < 25)
			it.elapsed_ms = lls_pkg::MS_W'(1000);
		else
			it.elapsed_ms = lls_pkg::MS_W'($urandom_range(1000));
		it.packet_valid = ($urandom_range(99) < 85);
		it.from_master = ($urandom_range(99) < 90);
		it.socket_failed = ($urandom_range(99) < 3);
		it.open_ok = ($urandom_range(99) < 80);
		roll = $urandom_range(99);
		if (ph == lls_pkg::PH_RUNNING) begin
			if (roll < 35) k = lls_pkg::KIND_DATA;
			else if (roll < 55) k = lls_pkg::KIND_PONG;
			else if (roll < 70) k = lls_pkg::KIND_BEACON;
			else if (roll < 76) k = lls_pkg::KIND_ACK;
			else if (roll < 80) k = lls_pkg::KIND_NAK;
			else if (roll < 83) k = lls_pkg::KIND_CLOSE;
			else k = lls_pkg::KIND_UNKNOWN;
		end else begin
			if (roll < 70) k = lls_pkg::KIND_ACK;
			else if (roll < 75) k = lls_pkg::KIND_NAK;
			else if (roll < 79) k = lls_pkg::KIND_CLOSE;
			else if (roll < 85) k = lls_pkg::KIND_DATA;
			else if (roll < 90) k = lls_pkg::KIND_PONG;
			else if (roll < 94) k = lls_pkg::KIND_BEACON;
			else k = lls_pkg::KIND_UNKNOWN;
		end
		it.header_bytes = header_for(k);
		return it;
	endfunction

	task automatic send_item(input lls_pkg::item_t it);
		while ($urandom_range(99) < sender_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		elapsed_ms <= it.elapsed_ms;
		packet_valid <= it.packet_valid;
		from_master <= it.from_master;
		header_bytes <= it.header_bytes;
		socket_failed <= it.socket_failed;
		open_ok <= it.open_ok;
		do
			@(posedge clk);
		while (!in_ready);
		sb.take_item(it);
	endtask

	task automatic write_regs(input int ret, input int tmo, input bit opt, input bit den);
		logic [lls_pkg::CIDX_W-1:0] idx[4];
		logic [lls_pkg::CFG_W-1:0] val[4];
		idx = '{lls_pkg::CFG_RETRY_PERIOD, lls_pkg::CFG_TIMEOUT_PERIOD,
			lls_pkg::CFG_OPTIONS, lls_pkg::CFG_DATA_EN};
		val = '{lls_pkg::CFG_W'(ret), lls_pkg::CFG_W'(tmo), lls_pkg::CFG_W'(opt),
			lls_pkg::CFG_W'(den)};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			sb.set_reg(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.due_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int ret, input int tmo, input bit opt, input bit den,
			input int idle, input int stall, input int n);
		write_regs(ret, tmo, opt, den);
		sender_idle = idle;
		stall_pct = stall;
		repeat (n)
			send_item(make_item(sb.ph));
		drain();
	endtask

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		sb = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		elapsed_ms <= '0;
		packet_valid <= 1'b0;
		from_master <= 1'b0;
		header_bytes <= '0;
		socket_failed <= 1'b0;
		open_ok <= 1'b0;
		out_ready <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_regs(1000, 262143, 1'b1, 1'b1);
		// socket failure ignored while connecting
		send_item(mk(0, 1, 1, header_for(lls_pkg::KIND_ACK), 1, 1));
		send_item(mk(1000, 0, 0, '0, 0, 0));
		send_item(mk(1000, 0, 0, '0, 0, 1));
		send_item(mk(0, 1, 0, header_for(lls_pkg::KIND_ACK), 0, 0));
		send_item(mk(0, 0, 1, header_for(lls_pkg::KIND_ACK), 0, 0));
		send_item(mk(0, 1, 1, header_for(lls_pkg::KIND_ACK), 0, 0));
		send_item(mk(0, 1, 1, header_for(lls_pkg::KIND_ACK), 0, 0));
		send_item(mk(0, 1, 1, header_for(lls_pkg::KIND_ACK), 0, 0));
		send_item(mk(0, 1, 1, header_for(lls_pkg::KIND_ACK), 0, 0));
		send_item(mk(0, 1, 1, header_for(lls_pkg::KIND_ACK), 0, 0));
		send_item(mk(0, 1, 1, header_for(lls_pkg::KIND_DATA), 0, 0));
		send_item(mk(0, 1, 1, header_for(lls_pkg::KIND_PONG), 0, 0));
		send_item(mk(0, 1, 1, header_for(lls_pkg::KIND_BEACON), 0, 0));
		send_item(mk(0, 1, 1, '1, 0, 0));
		send_item(mk(0, 1, 1, '0, 0, 0));
		send_item(mk(1000, 0, 0, '0, 0, 0));
		send_item(mk(0, 1, 1, header_for(lls_pkg::KIND_NAK), 0, 0));
		send_item(mk(0, 1, 1, header_for(lls_pkg::KIND_NAK), 0, 0));
		send_item(mk(1000, 0, 0, '0, 0, 1));
		send_item(mk(0, 1, 1, header_for(lls_pkg::KIND_ACK), 1, 1));
		send_item(mk(1000, 0, 0, '0, 0, 1));
		// close, then the retry timer expires in the same transaction
		send_item(mk(1000, 1, 1, header_for(lls_pkg::KIND_CLOSE), 0, 1));
		send_item(mk(0, 1, 1, header_for(lls_pkg::KIND_DATA), 0, 1));
		drain();

		run_phase(10000, 60000, 1'b0, 1'b0, 0, 0, 120);
		run_phase(1, 262143, 1'b1, 1'b1, 85, 0, 150);
		run_phase(3000, 5000, 1'b0, 1'b1, 0, 85, 150);
		run_phase(2000, 1, 1'b1, 1'b0, 23, 23, 100);
		// zero timeout period: the timeout timer never expires
		run_phase(1500, 0, 1'b1, 1'b1, 0, 0, 150);
		run_phase(262143, 262143, 1'b0, 1'b1, 23, 23, 100);
		run_phase(0, 4000, 1'b1, 1'b1, 85, 0, 50);
		run_phase(700, 9000, 1'b1, 1'b1, 23, 23, 100);

		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.due_reports.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> sim.f
hdl/lls_pkg.sv
hdl/lls_tag_decode.sv
hdl/lls_timer_step.sv
hdl/lls_step.sv
hdl/link_login_sequencer_core.sv
tb/link_login_sequencer_core_tb.sv
